FILE: rtl/core/matrix_multiply_engine_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the matrix multiply engine checker
// Wrap the clock, reset qualifier and error report around a property.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ENGINE_MACROS_SVH
`define MATRIX_MULTIPLY_ENGINE_MACROS_SVH

// Check on every rising edge outside reset.
`define MME_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check on every rising edge, reset included.
`define MME_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/core/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types, constants and register indexes of the matrix multiply engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mme_pkg;

    localparam int MAX_DIM_DEF    = 8;
    localparam int ELEM_WIDTH_DEF = 16;

    // Fixed field widths of the result word and the configuration port.
    localparam int SUM_W     = 35;
    localparam int OUT_IDX_W = 3;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'd1;

    localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,
        ST_RUN
    } t_state;

    // One dot-product term issued to the multiply-accumulate pipe.
    typedef struct packed {
        logic                 valid;
        logic                 first;
        logic                 last_k;
        logic                 is_last;
        logic [OUT_IDX_W-1:0] row;
        logic [OUT_IDX_W-1:0] col;
    } t_tag;

    // Pipe status seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic out_free;
    } t_mac_status;

endpackage

`default_nettype wire

FILE: rtl/core/mme_ram.sv
// ----------------------------------------------------------------------------
// mme_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mme_ram
    import mme_pkg::*;
#(
    parameter int WIDTH = ELEM_WIDTH_DEF,
    parameter int DEPTH = MAX_DIM_DEF * MAX_DIM_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_we,
    input  wire logic [AW-1:0]          i_waddr,
    input  wire logic [WIDTH-1:0]       i_wdata,
    input  wire logic [AW-1:0]          i_raddr,
    output logic      [WIDTH-1:0]       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/mme_seq.sv
// ----------------------------------------------------------------------------
// mme_seq
// Load control, configuration registers and the row/column/term sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mme_seq
    import mme_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
    localparam int DEPTH     = MAX_DIM * MAX_DIM,
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_addr,
    input  wire logic [CFG_W-1:0]             i_cfg_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic                         i_in_req_type,
    input  wire logic signed [ELEM_WIDTH-1:0] i_in_elem_value,
    output logic                              o_a_we,
    output logic [AW-1:0]                     o_a_waddr,
    output logic [AW-1:0]                     o_a_raddr,
    output logic                              o_b_we,
    output logic [AW-1:0]                     o_b_waddr,
    output logic [AW-1:0]                     o_b_raddr,
    output logic [ELEM_WIDTH-1:0]             o_wdata,
    output t_tag                              o_tag,
    input  t_mac_status                       i_status
);

    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_rows_cfg, r_cols_cfg;
    logic [FILL_W-1:0]  r_a_fill, n_a_fill;
    logic [FILL_W-1:0]  r_b_fill, n_b_fill;
    logic [IDX_W-1:0]   r_i, n_i, r_j, n_j, r_k, n_k;

    logic [DIM_W-1:0]   w_rows, w_cols;
    logic [FILL_W-1:0]  w_rc, w_cc, w_b_next;
    logic               w_in_acc, w_i_last, w_j_last, w_k_last;

    // Effective dimensions: zero acts as one, large values clamp to MAX_DIM.
    always_comb begin
        if (r_rows_cfg == '0) begin
            w_rows = DIM_W'(1);
        end else if (r_rows_cfg > CFG_W'(MAX_DIM)) begin
            w_rows = DIM_W'(MAX_DIM);
        end else begin
            w_rows = DIM_W'(r_rows_cfg);
        end
        if (r_cols_cfg == '0) begin
            w_cols = DIM_W'(1);
        end else if (r_cols_cfg > CFG_W'(MAX_DIM)) begin
            w_cols = DIM_W'(MAX_DIM);
        end else begin
            w_cols = DIM_W'(r_cols_cfg);
        end
    end

    assign w_rc     = FILL_W'(w_rows) * FILL_W'(w_cols);
    assign w_cc     = FILL_W'(w_cols) * FILL_W'(w_cols);
    assign w_i_last = DIM_W'(r_i) == (w_rows - DIM_W'(1));
    assign w_j_last = DIM_W'(r_j) == (w_cols - DIM_W'(1));
    assign w_k_last = DIM_W'(r_k) == (w_cols - DIM_W'(1));
    assign w_in_acc = i_in_valid && (r_state == ST_IDLE);
    assign w_b_next = (r_b_fill < FILL_W'(DEPTH)) ? r_b_fill + FILL_W'(1) : r_b_fill;

    assign o_in_stall = (r_state != ST_IDLE);
    assign o_wdata    = i_in_elem_value;
    assign o_a_waddr  = r_a_fill[AW-1:0];
    assign o_b_waddr  = r_b_fill[AW-1:0];
    assign o_a_raddr  = AW'(r_i) * AW'(w_cols) + AW'(r_k);
    assign o_b_raddr  = AW'(r_k) * AW'(w_cols) + AW'(r_j);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= DIM_RESET;
            r_cols_cfg <= DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_ROW_COUNT: r_rows_cfg <= i_cfg_data;
                REG_COL_COUNT: r_cols_cfg <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_a_fill <= '0;
            r_b_fill <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
        end else begin
            r_state  <= n_state;
            r_a_fill <= n_a_fill;
            r_b_fill <= n_b_fill;
            r_i      <= n_i;
            r_j      <= n_j;
            r_k      <= n_k;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_a_fill = r_a_fill;
        n_b_fill = r_b_fill;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        o_a_we   = 1'b0;
        o_b_we   = 1'b0;

        o_tag.valid   = (r_state == ST_RUN);
        o_tag.first   = (r_k == '0);
        o_tag.last_k  = w_k_last;
        o_tag.is_last = w_i_last && w_j_last;
        o_tag.row     = OUT_IDX_W'(r_i);
        o_tag.col     = OUT_IDX_W'(r_j);

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (!i_in_req_type) begin
                        // drop A words once A is full
                        if (r_a_fill < w_rc) begin
                            o_a_we   = 1'b1;
                            n_a_fill = r_a_fill + FILL_W'(1);
                        end
                    end else begin
                        o_b_we = (r_b_fill < FILL_W'(DEPTH));
                        if (w_b_next >= w_cc) begin
                            n_a_fill = '0;
                            n_b_fill = '0;
                            n_i      = '0;
                            n_j      = '0;
                            n_k      = '0;
                            n_state  = ST_WAIT;
                        end else begin
                            n_b_fill = w_b_next;
                        end
                    end
                end
            end
            ST_WAIT: begin
                // start the next element once the pipe and output slot are clear
                if (!i_status.busy && i_status.out_free) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_k_last) begin
                    n_k = '0;
                    if (w_j_last) begin
                        n_j = '0;
                        if (w_i_last) begin
                            n_i     = '0;
                            n_state = ST_IDLE;
                        end else begin
                            n_i     = r_i + IDX_W'(1);
                            n_state = ST_WAIT;
                        end
                    end else begin
                        n_j     = r_j + IDX_W'(1);
                        n_state = ST_WAIT;
                    end
                end else begin
                    n_k = r_k + IDX_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/mme_mac.sv
// ----------------------------------------------------------------------------
// mme_mac
// Multiply-accumulate pipe with the result output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mme_mac
    import mme_pkg::*;
#(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic signed [ELEM_WIDTH-1:0] i_a_rdata,
    input  wire logic signed [ELEM_WIDTH-1:0] i_b_rdata,
    input  t_tag                              i_tag,
    output t_mac_status                       o_status,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic signed [SUM_W-1:0]           o_out_prod_value,
    output logic [OUT_IDX_W-1:0]              o_out_row,
    output logic [OUT_IDX_W-1:0]              o_out_col,
    output logic                              o_out_is_last
);

    localparam int PROD_W = 2 * ELEM_WIDTH;

    t_tag                     r_tag1, r_tag2;
    logic signed [PROD_W-1:0] w_prod, r_prod;
    logic signed [SUM_W-1:0]  r_acc, w_base, w_sum;
    logic                     r_out_valid;
    logic signed [SUM_W-1:0]  r_out_value;
    logic [OUT_IDX_W-1:0]     r_out_row, r_out_col;
    logic                     r_out_last;

    assign w_prod = i_a_rdata * i_b_rdata;
    assign w_base = r_tag2.first ? SUM_W'(0) : r_acc;
    assign w_sum  = w_base + SUM_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1      <= '0;
            r_tag2      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            if (r_tag2.valid && r_tag2.last_k) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (r_tag2.valid) begin
            r_acc <= w_sum;
        end
        if (r_tag2.valid && r_tag2.last_k) begin
            r_out_value <= w_sum;
            r_out_row   <= r_tag2.row;
            r_out_col   <= r_tag2.col;
            r_out_last  <= r_tag2.is_last;
        end
    end

    assign o_status.busy     = r_tag1.valid || r_tag2.valid;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid      = r_out_valid;
    assign o_out_prod_value = r_out_value;
    assign o_out_row        = r_out_row;
    assign o_out_col        = r_out_col;
    assign o_out_is_last    = r_out_last;

endmodule

`default_nettype wire

FILE: rtl/core/matrix_multiply_engine.sv
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// Loads matrices A (rows x cols) and B (cols x cols), then streams out A*B.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry req_type (0 = next A element, 1 = next B element) and a
//   signed element, both matrices in row-major order. A word is taken when
//   i_in_valid is high and o_in_stall is low. A words beyond rows*cols are
//   dropped. The word that completes B starts the product. o_in_stall then
//   stays high until the last term of the last result has been issued.
//   Each result word (prod_value, row, col, is_last) is built in steps: a
//   wait state that checks that the pipe is empty and the output slot is
//   free, then one read per term through the single read port of each
//   store, then the multiply and add stages.
//   A stalled result holds in the output register; the sequencer waits
//   before each element until that register is free, so nothing is lost.
//   Reset clears the load counts, the sequencer and the output valid, and
//   sets row_count and col_count to 8. Store contents are not cleared.
//   Write row_count / col_count through the cfg port only while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply_engine
    import mme_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_addr,
    input  wire logic [CFG_W-1:0]             i_cfg_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic                         i_in_req_type,
    input  wire logic signed [ELEM_WIDTH-1:0] i_in_elem_value,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic signed [SUM_W-1:0]           o_out_prod_value,
    output logic [OUT_IDX_W-1:0]              o_out_row,
    output logic [OUT_IDX_W-1:0]              o_out_col,
    output logic                              o_out_is_last
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                  w_a_we, w_b_we;
    logic [AW-1:0]         w_a_waddr, w_a_raddr, w_b_waddr, w_b_raddr;
    logic [ELEM_WIDTH-1:0] w_wdata, w_a_rdata, w_b_rdata;
    t_tag                  w_tag;
    t_mac_status           w_status;

    // Load control, configuration and element/term sequencing.
    mme_seq #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_req_type   (i_in_req_type),
        .i_in_elem_value (i_in_elem_value),
        .o_a_we          (w_a_we),
        .o_a_waddr       (w_a_waddr),
        .o_a_raddr       (w_a_raddr),
        .o_b_we          (w_b_we),
        .o_b_waddr       (w_b_waddr),
        .o_b_raddr       (w_b_raddr),
        .o_wdata         (w_wdata),
        .o_tag           (w_tag),
        .i_status        (w_status)
    );

    // Element store for A, row-major at i*cols + k.
    mme_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_a_ram (
        .i_clk   (i_clk),
        .i_we    (w_a_we),
        .i_waddr (w_a_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_a_raddr),
        .o_rdata (w_a_rdata)
    );

    // Element store for B, row-major at k*cols + j.
    mme_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_b_ram (
        .i_clk   (i_clk),
        .i_we    (w_b_we),
        .i_waddr (w_b_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_b_raddr),
        .o_rdata (w_b_rdata)
    );

    // Multiply, accumulate over k, hold the finished word for the receiver.
    mme_mac #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_mac (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_a_rdata        (w_a_rdata),
        .i_b_rdata        (w_b_rdata),
        .i_tag            (w_tag),
        .o_status         (w_status),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_prod_value (o_out_prod_value),
        .o_out_row        (o_out_row),
        .o_out_col        (o_out_col),
        .o_out_is_last    (o_out_is_last)
    );

endmodule

`default_nettype wire

FILE: rtl/core/mme_checker.sv
// ----------------------------------------------------------------------------
// mme_checker
// Port-level assertions for the matrix multiply engine, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "matrix_multiply_engine_macros.svh"

module mme_checker
    import mme_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_cfg_we,
    input wire logic [CFG_IDX_W-1:0]         i_cfg_addr,
    input wire logic [CFG_W-1:0]             i_cfg_data,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_stall,
    input wire logic                         i_in_req_type,
    input wire logic signed [ELEM_WIDTH-1:0] i_in_elem_value,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_stall,
    input wire logic signed [SUM_W-1:0]      o_out_prod_value,
    input wire logic [OUT_IDX_W-1:0]         o_out_row,
    input wire logic [OUT_IDX_W-1:0]         o_out_col,
    input wire logic                         o_out_is_last
);

    logic [CFG_W-1:0]              r_rows_cfg, r_cols_cfg;
    logic [CFG_W-1:0]              w_rows, w_cols;
    logic [OUT_IDX_W-1:0]          w_last_row, w_last_col;
    logic                          w_at_corner;
    logic [ELEM_WIDTH:0]           w_in_word;
    logic [SUM_W+2*OUT_IDX_W:0]    w_out_word;

    // Shadow the dimension registers from the cfg port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= DIM_RESET;
            r_cols_cfg <= DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_ROW_COUNT: r_rows_cfg <= i_cfg_data;
                REG_COL_COUNT: r_cols_cfg <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        if (r_rows_cfg == '0) begin
            w_rows = CFG_W'(1);
        end else if (r_rows_cfg > CFG_W'(MAX_DIM)) begin
            w_rows = CFG_W'(MAX_DIM);
        end else begin
            w_rows = r_rows_cfg;
        end
        if (r_cols_cfg == '0) begin
            w_cols = CFG_W'(1);
        end else if (r_cols_cfg > CFG_W'(MAX_DIM)) begin
            w_cols = CFG_W'(MAX_DIM);
        end else begin
            w_cols = r_cols_cfg;
        end
    end

    assign w_last_row  = OUT_IDX_W'(w_rows - CFG_W'(1));
    assign w_last_col  = OUT_IDX_W'(w_cols - CFG_W'(1));
    assign w_at_corner = (o_out_row == w_last_row) && (o_out_col == w_last_col);
    assign w_in_word   = {i_in_req_type, i_in_elem_value};
    assign w_out_word  = {o_out_prod_value, o_out_row, o_out_col, o_out_is_last};

    // Reset leaves no result pending and the input open.
    `MME_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !o_out_valid && !o_in_stall, "reset did not clear")

    // Hold a stalled input word.
    `MME_ASSERT(a_in_hold, i_in_valid && o_in_stall |=> i_in_valid && $stable(w_in_word), "input changed")

    // Hold a stalled result word.
    `MME_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid, "result dropped under stall")
    `MME_ASSERT(a_out_stable, o_out_valid && i_out_stall |=> $stable(w_out_word), "stalled result changed")

    // The final word of a product sits at the last row and column.
    `MME_ASSERT(a_last_corner, o_out_valid && o_out_is_last |-> w_at_corner, "last mark off the corner")

endmodule

bind matrix_multiply_engine mme_checker #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
) u_checker (.*);

`default_nettype wire
